>>> src/pbre_pkg.sv
// Shared types and constants of the PackBits row encoder.
package pbre_pkg;

    // Longest run or literal stretch that one header may describe.
    localparam int MAX_SPAN = 128;
    localparam int LEN_W    = $clog2(MAX_SPAN + 1);
    localparam int ADDR_W   = $clog2(MAX_SPAN);

    typedef logic [7:0]        t_byte;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [ADDR_W-1:0] t_addr;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TAKE,
        ST_CHK,
        ST_ROW_END,
        ST_RUN_HDR,
        ST_RUN_VAL,
        ST_LIT_HDR,
        ST_LIT_DAT,
        ST_FIN
    } t_state;

    // Request from the sequencer to the word packer.
    typedef struct packed {
        logic  push;
        logic  flush;
        logic  flush_last;
        t_byte data;
    } t_pack_cmd;

endpackage

>>> src/pbre_if.sv
// Stream interfaces for the raw byte input and the packed word output.
interface pbre_in_if;
    logic            valid;
    logic            ready;
    pbre_pkg::t_byte in_byte;
    logic            in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pbre_out_if;
    logic            valid;
    logic            ready;
    pbre_pkg::t_byte out_byte0;
    pbre_pkg::t_byte out_byte1;
    pbre_pkg::t_byte out_byte2;
    pbre_pkg::t_byte out_byte3;
    logic [2:0]      out_count;
    logic            out_last;

    modport source (output valid, output out_byte0, output out_byte1, output out_byte2,
                    output out_byte3, output out_count, output out_last, input ready);
    modport sink   (input valid, input out_byte0, input out_byte1, input out_byte2,
                    input out_byte3, input out_count, input out_last, output ready);
endinterface

>>> src/pbre_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pbre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/pbre_packer.sv
// Packs coded bytes four to a word and holds the word in the output register.
module pbre_packer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pbre_pkg::t_pack_cmd i_cmd,
    output logic                o_ack,
    pbre_out_if.source          o_out
);

    pbre_pkg::t_byte r_buf [4];
    logic [2:0]      r_fill;
    pbre_pkg::t_byte r_ob  [4];
    logic [2:0]      r_ocnt;
    logic            r_olast;
    logic            r_ovalid;

    logic            w_full;
    logic            w_out_free;
    logic            w_need_flush;
    logic            w_emit_push;
    logic            w_emit_flush;
    logic            w_emit;
    pbre_pkg::t_byte w_masked [4];

    // A full word waits for the next byte or for the end of the item, so that
    // the final word of a row can still be marked as last.
    always_comb begin
        w_full       = (r_fill == 3'd4);
        w_out_free   = !r_ovalid || o_out.ready;
        w_need_flush = i_cmd.flush_last ? (r_fill != 3'd0) : w_full;
        if (i_cmd.push) begin
            o_ack = !w_full || w_out_free;
        end else if (i_cmd.flush) begin
            o_ack = !w_need_flush || w_out_free;
        end else begin
            o_ack = 1'b0;
        end
        w_emit_push  = i_cmd.push && w_full && w_out_free;
        w_emit_flush = !i_cmd.push && i_cmd.flush && w_need_flush && w_out_free;
        w_emit       = w_emit_push || w_emit_flush;
        for (int k = 0; k < 4; k++) begin
            w_masked[k] = (3'(k) < r_fill) ? r_buf[k] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill   <= 3'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.push && o_ack) begin
                r_fill <= w_full ? 3'd1 : r_fill + 3'd1;
            end else if (w_emit_flush) begin
                r_fill <= 3'd0;
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push && o_ack) begin
            if (w_full) begin
                r_buf[0] <= i_cmd.data;
            end else begin
                r_buf[r_fill[1:0]] <= i_cmd.data;
            end
        end
        if (w_emit) begin
            r_ob    <= w_masked;
            r_ocnt  <= r_fill;
            r_olast <= w_emit_flush && i_cmd.flush_last;
        end
    end

    assign o_out.valid     = r_ovalid;
    assign o_out.out_byte0 = r_ob[0];
    assign o_out.out_byte1 = r_ob[1];
    assign o_out.out_byte2 = r_ob[2];
    assign o_out.out_byte3 = r_ob[3];
    assign o_out.out_count = r_ocnt;
    assign o_out.out_last  = r_olast;

endmodule

>>> src/packbits_row_encoder.sv
// Top level of the PackBits row encoder: classification sequencer and literal store.
//
//   Channel  Direction  Transfer moves                       Handshake
//   i_in     sink       in_byte, in_last (one raw byte)      valid / ready
//   o_out    source     out_byte0..3, out_count, out_last    valid / ready
//
// One raw byte passes through accept, classify, cap check and word check, and each
// coded byte it releases into the packer is pushed in a state of its own; a literal
// flush sends its header, then reads the store one entry a cycle while the packer
// accepts. At the last byte of a row the row-end state takes in each leftover
// lookahead byte, comes before each flush started there, and closes the row.
// A coded byte that follows a full word, and the word flush at the end of an
// item, wait while the packer's output register holds an untransferred word.
// Reset (i_rst_n low, synchronous) empties the lookahead, the pending run,
// the pending literal and the packer; the literal store needs no clearing.
// i_in.ready is high only while the sequencer is idle.
module packbits_row_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    pbre_in_if.sink    i_in,
    pbre_out_if.source o_out
);

    pbre_pkg::t_state    r_state, n_state;
    pbre_pkg::t_state    r_ret,   n_ret;
    pbre_pkg::t_byte     r_cur,   n_cur;
    logic                r_last,  n_last;
    pbre_pkg::t_byte     r_la0,   n_la0;
    pbre_pkg::t_byte     r_la1,   n_la1;
    logic [1:0]          r_fill,  n_fill;
    pbre_pkg::t_len      r_lit_len, n_lit_len;
    pbre_pkg::t_byte     r_run_val, n_run_val;
    pbre_pkg::t_len      r_run_len, n_run_len;
    logic                r_in_run,  n_in_run;
    pbre_pkg::t_addr     r_idx,     n_idx;

    pbre_pkg::t_pack_cmd w_cmd;
    logic                w_ack;
    logic                w_we;
    pbre_pkg::t_addr     w_waddr;
    pbre_pkg::t_byte     w_wdata;
    logic                w_re;
    pbre_pkg::t_addr     w_raddr;
    pbre_pkg::t_byte     w_rdata;

    logic                w_triple;
    logic                w_lit_full;
    logic                w_run_full;
    logic                w_lit_done;

    assign w_triple   = (r_la0 == r_la1) && (r_la1 == r_cur);
    assign w_lit_full = (r_lit_len == pbre_pkg::t_len'(pbre_pkg::MAX_SPAN));
    assign w_run_full = r_in_run && (r_run_len >= pbre_pkg::t_len'(pbre_pkg::MAX_SPAN));
    assign w_lit_done = ((pbre_pkg::t_len'(r_idx) + pbre_pkg::t_len'(1)) == r_lit_len);

    assign i_in.ready = (r_state == pbre_pkg::ST_IDLE);

    // Literal store: one entry per byte of the pending literal stretch.
    pbre_ram #(
        .WIDTH (8),
        .DEPTH (pbre_pkg::MAX_SPAN)
    ) u_lit_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pbre_packer u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_ack   (w_ack),
        .o_out   (o_out)
    );

    // Next state. Flushes of a run or a literal are subroutines that return to
    // the state held in r_ret.
    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        unique case (r_state)
            pbre_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_state = pbre_pkg::ST_TAKE;
                end
            end
            pbre_pkg::ST_TAKE: begin
                n_state = pbre_pkg::ST_CHK;
                if (r_in_run) begin
                    if (r_cur != r_run_val) begin
                        n_state = pbre_pkg::ST_RUN_HDR;
                        n_ret   = pbre_pkg::ST_CHK;
                    end
                end else if (r_fill == 2'd2 && w_triple && r_lit_len != '0) begin
                    n_state = pbre_pkg::ST_LIT_HDR;
                    n_ret   = pbre_pkg::ST_CHK;
                end
            end
            pbre_pkg::ST_CHK: begin
                if (w_lit_full) begin
                    n_state = pbre_pkg::ST_LIT_HDR;
                    n_ret   = pbre_pkg::ST_CHK;
                end else if (w_run_full) begin
                    n_state = pbre_pkg::ST_RUN_HDR;
                    n_ret   = pbre_pkg::ST_CHK;
                end else if (r_last) begin
                    n_state = pbre_pkg::ST_ROW_END;
                end else begin
                    n_state = pbre_pkg::ST_FIN;
                end
            end
            pbre_pkg::ST_ROW_END: begin
                if (r_in_run) begin
                    n_state = pbre_pkg::ST_RUN_HDR;
                    n_ret   = pbre_pkg::ST_ROW_END;
                end else if (w_lit_full) begin
                    n_state = pbre_pkg::ST_LIT_HDR;
                    n_ret   = pbre_pkg::ST_ROW_END;
                end else if (r_fill != 2'd0) begin
                    n_state = pbre_pkg::ST_ROW_END;
                end else if (r_lit_len != '0) begin
                    n_state = pbre_pkg::ST_LIT_HDR;
                    n_ret   = pbre_pkg::ST_FIN;
                end else begin
                    n_state = pbre_pkg::ST_FIN;
                end
            end
            pbre_pkg::ST_RUN_HDR: begin
                if (w_ack) begin
                    n_state = pbre_pkg::ST_RUN_VAL;
                end
            end
            pbre_pkg::ST_RUN_VAL: begin
                if (w_ack) begin
                    n_state = r_ret;
                end
            end
            pbre_pkg::ST_LIT_HDR: begin
                if (w_ack) begin
                    n_state = pbre_pkg::ST_LIT_DAT;
                end
            end
            pbre_pkg::ST_LIT_DAT: begin
                if (w_ack && w_lit_done) begin
                    n_state = r_ret;
                end
            end
            pbre_pkg::ST_FIN: begin
                if (w_ack) begin
                    n_state = pbre_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = pbre_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath updates, packer requests and literal store ports.
    always_comb begin
        n_cur     = r_cur;
        n_last    = r_last;
        n_la0     = r_la0;
        n_la1     = r_la1;
        n_fill    = r_fill;
        n_lit_len = r_lit_len;
        n_run_val = r_run_val;
        n_run_len = r_run_len;
        n_in_run  = r_in_run;
        n_idx     = r_idx;
        w_cmd     = '0;
        w_we      = 1'b0;
        w_waddr   = r_lit_len[pbre_pkg::ADDR_W-1:0];
        w_wdata   = r_la0;
        w_re      = 1'b0;
        w_raddr   = '0;
        unique case (r_state)
            pbre_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_cur  = i_in.in_byte;
                    n_last = i_in.in_last;
                end
            end
            pbre_pkg::ST_TAKE: begin
                if (r_in_run) begin
                    if (r_cur == r_run_val) begin
                        n_run_len = r_run_len + pbre_pkg::t_len'(1);
                    end else begin
                        // The run ends; this byte opens a fresh lookahead.
                        n_la0  = r_cur;
                        n_fill = 2'd1;
                    end
                end else if (r_fill == 2'd0) begin
                    n_la0  = r_cur;
                    n_fill = 2'd1;
                end else if (r_fill == 2'd1) begin
                    n_la1  = r_cur;
                    n_fill = 2'd2;
                end else if (w_triple) begin
                    n_run_val = r_cur;
                    n_run_len = pbre_pkg::t_len'(3);
                    n_in_run  = 1'b1;
                    n_fill    = 2'd0;
                end else begin
                    // The oldest lookahead byte cannot start a triple any more.
                    w_we      = 1'b1;
                    n_lit_len = r_lit_len + pbre_pkg::t_len'(1);
                    n_la0     = r_la1;
                    n_la1     = r_cur;
                end
            end
            pbre_pkg::ST_ROW_END: begin
                if (!r_in_run && !w_lit_full && r_fill != 2'd0) begin
                    // At the row end the leftover lookahead joins the literal.
                    w_we      = 1'b1;
                    n_lit_len = r_lit_len + pbre_pkg::t_len'(1);
                    n_la0     = r_la1;
                    n_fill    = r_fill - 2'd1;
                end
            end
            pbre_pkg::ST_RUN_HDR: begin
                w_cmd.push = 1'b1;
                w_cmd.data = 8'd1 - pbre_pkg::t_byte'(r_run_len);
            end
            pbre_pkg::ST_RUN_VAL: begin
                w_cmd.push = 1'b1;
                w_cmd.data = r_run_val;
                if (w_ack) begin
                    n_in_run  = 1'b0;
                    n_run_len = '0;
                end
            end
            pbre_pkg::ST_LIT_HDR: begin
                w_cmd.push = 1'b1;
                w_cmd.data = pbre_pkg::t_byte'(r_lit_len) - 8'd1;
                if (w_ack) begin
                    w_re  = 1'b1;
                    n_idx = '0;
                end
            end
            pbre_pkg::ST_LIT_DAT: begin
                w_cmd.push = 1'b1;
                w_cmd.data = w_rdata;
                if (w_ack) begin
                    if (w_lit_done) begin
                        n_lit_len = '0;
                    end else begin
                        // Fetch the next entry only once the current one is taken.
                        w_re    = 1'b1;
                        w_raddr = r_idx + pbre_pkg::t_addr'(1);
                        n_idx   = r_idx + pbre_pkg::t_addr'(1);
                    end
                end
            end
            pbre_pkg::ST_FIN: begin
                w_cmd.flush      = 1'b1;
                w_cmd.flush_last = r_last;
            end
            pbre_pkg::ST_CHK: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pbre_pkg::ST_IDLE;
            r_ret     <= pbre_pkg::ST_IDLE;
            r_fill    <= 2'd0;
            r_lit_len <= '0;
            r_run_len <= '0;
            r_in_run  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_ret     <= n_ret;
            r_fill    <= n_fill;
            r_lit_len <= n_lit_len;
            r_run_len <= n_run_len;
            r_in_run  <= n_in_run;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_last    <= n_last;
        r_la0     <= n_la0;
        r_la1     <= n_la1;
        r_run_val <= n_run_val;
        r_idx     <= n_idx;
    end

`ifndef SYNTH
    // The literal stretch never outgrows its store.
    a_lit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lit_len <= pbre_pkg::t_len'(pbre_pkg::MAX_SPAN))
        else $error("literal length exceeds the store depth");

    // While a run is pending, at most the byte that broke it waits in lookahead.
    a_run_lookahead: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_run |-> (r_fill <= 2'd1))
        else $error("run pending with two lookahead bytes");

    // Between items no capped run or full literal is left behind.
    a_idle_caps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pbre_pkg::ST_IDLE) |-> (!w_run_full && !w_lit_full))
        else $error("capped span left pending at idle");

    // A word is never shown with an empty or impossible count.
    a_out_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.out_count != 3'd0 && o_out.out_count <= 3'd4))
        else $error("output word with bad byte count");
`endif

endmodule
